### src/urs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urs_pkg
// Types and constants shared by the ultrasonic range sequencer files.
// ----------------------------------------------------------------------------
package urs_pkg;

  // one poll
  typedef struct packed {
    logic [31:0] now_us;
    logic        echo_level;
  } urs_in_t;

  // one result
  typedef struct packed {
    logic        trigger_level;
    logic        trigger_driven;
    logic [14:0] range_value;
    logic        done_res;
    logic [2:0]  phase;
  } urs_out_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SINGLE_PIN   = 3'd0,
    CFG_TRIG_WIDTH   = 3'd1,
    CFG_SETTLE       = 3'd2,
    CFG_RISE_TIMEOUT = 3'd3,
    CFG_ECHO_TIMEOUT = 3'd4
  } urs_cfg_idx_e;

  typedef struct packed {
    logic        single_pin;
    logic [7:0]  trigger_width_us;
    logic [15:0] settle_us;
    logic [15:0] rise_timeout_us;
    logic [15:0] echo_timeout_us;
  } urs_cfg_t;

  // ranging phases, one-hot
  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_TRIG   = 5'b00010,
    PH_SETTLE = 5'b00100,
    PH_RISE   = 5'b01000,
    PH_FALL   = 5'b10000
  } urs_phase_e;

  // numeric phase codes as seen on the result
  localparam logic [2:0] PH_NUM_START  = 3'd0;
  localparam logic [2:0] PH_NUM_TRIG   = 3'd1;
  localparam logic [2:0] PH_NUM_SETTLE = 3'd2;
  localparam logic [2:0] PH_NUM_RISE   = 3'd3;
  localparam logic [2:0] PH_NUM_FALL   = 3'd4;

  typedef struct packed {
    urs_phase_e  phase;
    logic [31:0] start_time;
    logic [31:0] entry_time;
    logic [14:0] last_value;
    logic        trig_out;
  } urs_state_t;

  // reset values of the configuration registers
  localparam logic        CFG_RST_SINGLE_PIN = 1'b0;
  localparam logic [7:0]  CFG_RST_TRIG_WIDTH = 8'd5;
  localparam logic [15:0] CFG_RST_SETTLE     = 16'd100;
  localparam logic [15:0] CFG_RST_RISE_TO    = 16'd1000;
  localparam logic [15:0] CFG_RST_ECHO_TO    = 16'd21000;

  localparam logic [14:0] RISE_SENTINEL = 15'd20001;
  localparam logic [14:0] FALL_SENTINEL = 15'd21000;
  localparam logic [14:0] RANGE_MAX     = 15'd21002;

  // width*1716/10000 is exact as (width*MM_RECIP) >> MM_SHIFT for width below
  // MM_SAT_WIDTH; from MM_SAT_WIDTH upwards the distance saturates to RANGE_MAX
  localparam int unsigned MM_SHIFT     = 29;
  localparam logic [26:0] MM_RECIP     = 27'd92127049;
  localparam logic [31:0] MM_SAT_WIDTH = 32'd122396;

endpackage

### src/urs_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urs_cfg
// Configuration registers, written through a valid/ready write channel.
// ----------------------------------------------------------------------------
module urs_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output urs_pkg::urs_cfg_t cfg_o
);
  import urs_pkg::*;

  urs_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.single_pin       <= CFG_RST_SINGLE_PIN;
      cfg_q.trigger_width_us <= CFG_RST_TRIG_WIDTH;
      cfg_q.settle_us        <= CFG_RST_SETTLE;
      cfg_q.rise_timeout_us  <= CFG_RST_RISE_TO;
      cfg_q.echo_timeout_us  <= CFG_RST_ECHO_TO;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SINGLE_PIN:   cfg_q.single_pin       <= cfg_data_i[0];
        CFG_TRIG_WIDTH:   cfg_q.trigger_width_us <= cfg_data_i[7:0];
        CFG_SETTLE:       cfg_q.settle_us        <= cfg_data_i;
        CFG_RISE_TIMEOUT: cfg_q.rise_timeout_us  <= cfg_data_i;
        CFG_ECHO_TIMEOUT: cfg_q.echo_timeout_us  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

### src/urs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urs_step
// Next-state and result logic for one poll of the ranging sequence.
// ----------------------------------------------------------------------------
module urs_step (
  input  urs_pkg::urs_cfg_t   cfg_i,
  input  urs_pkg::urs_state_t state_i,
  input  urs_pkg::urs_in_t    item_i,
  output urs_pkg::urs_state_t state_o,
  output urs_pkg::urs_out_t   result_o
);
  import urs_pkg::*;

  logic [31:0] el_start;
  logic [31:0] el_entry;
  logic [43:0] mm_prod;
  logic [14:0] mm_val;
  logic        done;
  logic [2:0]  phase_num;
  urs_state_t  nxt;

  assign el_start = item_i.now_us - state_i.start_time;
  assign el_entry = item_i.now_us - state_i.entry_time;

  // pulse width to millimetres, one constant multiply
  assign mm_prod = {10'd0, el_entry[16:0]} * {17'd0, MM_RECIP};
  assign mm_val  = (el_entry >= MM_SAT_WIDTH) ? RANGE_MAX : mm_prod[MM_SHIFT +: 15];

  always_comb begin
    nxt  = state_i;
    done = 1'b0;
    case (state_i.phase)
      PH_TRIG: begin
        if (el_start > {24'd0, cfg_i.trigger_width_us}) begin
          nxt.trig_out   = 1'b0;
          nxt.phase      = PH_SETTLE;
          nxt.entry_time = item_i.now_us;
        end
      end
      PH_SETTLE, PH_RISE: begin
        // settle falls straight through into the rise check
        if (state_i.phase == PH_SETTLE && el_entry > {16'd0, cfg_i.settle_us}) begin
          nxt.phase      = PH_RISE;
          nxt.entry_time = item_i.now_us;
        end
        if (item_i.echo_level) begin
          nxt.phase      = PH_FALL;
          nxt.entry_time = item_i.now_us;
        end else if (el_start > {16'd0, cfg_i.rise_timeout_us}) begin
          nxt.last_value = RISE_SENTINEL;
          nxt.phase      = PH_START;
          nxt.entry_time = item_i.now_us;
          done           = 1'b1;
        end
      end
      PH_FALL: begin
        if (!item_i.echo_level) begin
          nxt.last_value = mm_val;
          nxt.phase      = PH_START;
          nxt.entry_time = item_i.now_us;
          done           = 1'b1;
        end else if (el_start > {16'd0, cfg_i.echo_timeout_us}) begin
          nxt.last_value = FALL_SENTINEL;
          nxt.phase      = PH_START;
          nxt.entry_time = item_i.now_us;
          done           = 1'b1;
        end
      end
      default: begin
        nxt.phase      = PH_TRIG;
        nxt.trig_out   = 1'b1;
        nxt.start_time = item_i.now_us;
        nxt.entry_time = '0;
      end
    endcase
  end

  always_comb begin
    case (nxt.phase)
      PH_TRIG:   phase_num = PH_NUM_TRIG;
      PH_SETTLE: phase_num = PH_NUM_SETTLE;
      PH_RISE:   phase_num = PH_NUM_RISE;
      PH_FALL:   phase_num = PH_NUM_FALL;
      default:   phase_num = PH_NUM_START;
    endcase
  end

  assign state_o                 = nxt;
  assign result_o.trigger_level  = nxt.trig_out;
  assign result_o.trigger_driven = cfg_i.single_pin ? (nxt.phase == PH_TRIG) : 1'b1;
  assign result_o.range_value    = nxt.last_value;
  assign result_o.done_res       = done;
  assign result_o.phase          = phase_num;

endmodule

### src/ultrasonic_range_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_range_sequencer
// Trigger pulse, echo timer and distance conversion for an ultrasonic ranger.
// ----------------------------------------------------------------------------
// Takes one poll per clock while the output is not stalled and gives one result
// beat per poll. A poll is caught in an input register, the phase logic and the
// constant-scaled width conversion then run on it combinationally and the result
// lands in an output register. The phase state is updated together with that
// register, which is what lets the next poll follow straight behind. The input
// side keeps taking beats while a result waits, until both registers are full.
module ultrasonic_range_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  urs_pkg::urs_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output urs_pkg::urs_out_t out_data_o
);
  import urs_pkg::*;

  urs_cfg_t   cfg;
  urs_state_t state_q, state_d;
  urs_in_t    item_q;
  logic       item_vld_q;
  urs_out_t   res_q, res_d;
  logic       res_vld_q;
  logic       advance;

  urs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  urs_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // a poll moves on when the result slot is free or being emptied
  assign advance    = item_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      state_q    <= '{phase: PH_START, start_time: '0, entry_time: '0,
                      last_value: '0, trig_out: 1'b0};
    end else begin
      if (in_ready_o) begin
        item_vld_q <= in_valid_i;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_data_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

endmodule

### src/urs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urs_checker
// Port-level checks on the result beats of the range sequencer.
// ----------------------------------------------------------------------------
module urs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input urs_pkg::urs_out_t out_data_o
);
  import urs_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // a finished measurement always lands back in the start phase
  a_done_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> out_data_o.phase == PH_NUM_START)
    else $error("done without return to start phase");

  // trigger is high exactly while in the trigger phase
  a_trig_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.trigger_level == (out_data_o.phase == PH_NUM_TRIG))
    else $error("trigger level out of step with phase");

  // the trigger pin is always an output while it is being driven high
  a_trig_driven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.trigger_level |-> out_data_o.trigger_driven)
    else $error("trigger high on an undriven pin");

  a_range_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.range_value <= RANGE_MAX)
    else $error("range value above saturation limit");

endmodule

bind ultrasonic_range_sequencer urs_checker u_urs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
